// ===== rtl/core/rmsn_pkg.sv =====
// Shared types, constants and width helpers for the RMS normalizer.
// Used by rms_normalizer_top and rmsn_root; depends on nothing.
package rmsn_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS = 12;
	localparam int LENGTH_W = 13;
	localparam int EPS_W = 25;
	localparam int INV_W = 25;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 25;
	localparam int MAX_LENGTH_DEFAULT = 4096;

	localparam logic [INV_W-1:0] ONE_Q24 = INV_W'(1) << 24;
	localparam logic [LENGTH_W-1:0] VECTOR_LENGTH_RESET = LENGTH_W'(4096);
	localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(168);

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_LENGTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_EPSILON = CFG_INDEX_W'(1);

	// Item opcodes
	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_NORMALIZE = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [SAMPLE_BITS-1:0] x_value;
		logic signed [SAMPLE_BITS-1:0] gain;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] y_value;
		logic saturated;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_LAUNCH,
		ST_ROOT,
		ST_SCALE,
		ST_WEIGHT,
		ST_DELIVER
	} rmsn_state_t;

	typedef enum logic [2:0] {
		RP_IDLE,
		RP_DIVIDE,
		RP_OFFSET,
		RP_ROOT,
		RP_SETUP,
		RP_RECIP,
		RP_DONE
	} root_phase_t;

	// Longest vector the length register can select under a given build limit.
	function automatic int len_limit(int max_length);
		return (max_length < (1 << LENGTH_W) - 1) ? max_length : (1 << LENGTH_W) - 1;
	endfunction

	function automatic int len_width(int max_length);
		return $clog2(len_limit(max_length) + 1);
	endfunction

	// One square is at most 2^(2*SAMPLE_BITS-2); a pass sums at most len_limit of them.
	function automatic int sum_width(int max_length);
		return 2 * SAMPLE_BITS - 1 + $clog2(len_limit(max_length));
	endfunction

endpackage

// ===== rtl/core/rms_normalizer_top.sv =====
// RMS normalizer top level: item and result channels, config port, sequencer.
// Normalize item: scale, weight, then delivery, where the result register loads once the
// output is free. Accumulate item: square, then accumulate; a pass-closing item adds launch,
// division, root and reciprocal; a zero root skips the reciprocal. Items stall until the
// sequencer is idle again. Async active-low reset clears sequencer, sums, count, inverse rms
// (0) and config. Depends on rmsn_pkg, rmsn_mul, rmsn_root.
module rms_normalizer_top #(
	parameter int MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  rmsn_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output rmsn_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rmsn_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rmsn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rmsn_pkg::*;

	localparam int LEN_LIMIT = len_limit(MAX_LENGTH);
	localparam int LEN_W = len_width(MAX_LENGTH);
	localparam int SUM_W = sum_width(MAX_LENGTH);
	// Multiplier operand A carries the sample to square, the inverse rms or the scaled sample t.
	localparam int T_W = SAMPLE_BITS + INV_W + 1 - FRAC_BITS;
	localparam int MA_W = (T_W > INV_W + 1) ? T_W : INV_W + 1;
	localparam int P_W = MA_W + SAMPLE_BITS;
	localparam int YF_W = P_W - FRAC_BITS;

	rmsn_state_t state_q, state_d;

	item_t                      item_q;
	result_t                    res_q;
	logic                       res_valid_q;
	logic [LENGTH_W-1:0]        vector_length_q;
	logic [EPS_W-1:0]           epsilon_q;
	logic [SUM_W-1:0]           sum_q, sum_next;
	logic [LEN_W-1:0]           items_q, items_next, eff_len;
	logic                       pass_last;
	logic                       accept;
	logic                       out_free;
	logic                       load_res;

	logic                       mul_en;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [P_W-1:0]      prod;
	logic signed [MA_W-1:0]     t_val;
	logic signed [YF_W-1:0]     y_full;
	logic                       sat_hi, sat_lo;
	result_t                    res_d;

	logic                       root_start, root_done;
	logic [INV_W-1:0]           inv_rms;

	// Handshakes: one beat at a time in, result register decouples the output side.
	assign accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign result = res_q;

	// Effective length: zero reads as one, clamp to the build limit.
	always_comb begin
		if (vector_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(vector_length_q) > LEN_LIMIT) begin
			eff_len = LEN_W'(LEN_LIMIT);
		end else begin
			eff_len = LEN_W'(vector_length_q);
		end
	end

	// Square comes back from the shared multiplier; it is never negative.
	assign sum_next = sum_q + SUM_W'(prod[2*SAMPLE_BITS-2:0]);
	assign items_next = items_q + LEN_W'(1);
	assign pass_last = (items_next >= eff_len);

	// Floor shifts of the registered product
	assign t_val = MA_W'(prod >>> FRAC_BITS);
	assign y_full = YF_W'(prod >>> FRAC_BITS);
	assign sat_hi = !y_full[YF_W-1] && (|y_full[YF_W-2:SAMPLE_BITS-1]);
	assign sat_lo = y_full[YF_W-1] && !(&y_full[YF_W-2:SAMPLE_BITS-1]);

	always_comb begin
		res_d.saturated = sat_hi || sat_lo;
		if (sat_hi) begin
			res_d.y_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (sat_lo) begin
			res_d.y_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res_d.y_value = y_full[SAMPLE_BITS-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = (item.op == OP_NORMALIZE) ? ST_SCALE : ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_ACCUM;
			ST_ACCUM: state_d = pass_last ? ST_LAUNCH : ST_IDLE;
			ST_LAUNCH: state_d = ST_ROOT;
			ST_ROOT: begin
				if (root_done) state_d = ST_IDLE;
			end
			ST_SCALE: state_d = ST_WEIGHT;
			ST_WEIGHT: state_d = ST_DELIVER;
			ST_DELIVER: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: stall, multiplier operand steering, root launch, result load.
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		root_start = (state_q == ST_LAUNCH);
		load_res = (state_q == ST_DELIVER) && out_free;
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQUARE: begin
				mul_en = 1'b1;
				mul_a = MA_W'(item_q.x_value);
				mul_b = item_q.x_value;
			end
			ST_SCALE: begin
				mul_en = 1'b1;
				mul_a = $signed(MA_W'(inv_rms));
				mul_b = item_q.x_value;
			end
			ST_WEIGHT: begin
				mul_en = 1'b1;
				mul_a = t_val;
				mul_b = item_q.gain;
			end
			default: begin
			end
		endcase
	end

	rmsn_mul #(
		.A_W (MA_W),
		.B_W (SAMPLE_BITS)
	) u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	rmsn_root #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.sum     (sum_q),
		.len     (eff_len),
		.epsilon (epsilon_q),
		.done    (root_done),
		.inv     (inv_rms)
	);

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vector_length_q <= VECTOR_LENGTH_RESET;
			epsilon_q <= EPSILON_RESET;
			sum_q <= '0;
			items_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_VECTOR_LENGTH: vector_length_q <= cfg_data[LENGTH_W-1:0];
					REG_EPSILON: epsilon_q <= cfg_data[EPS_W-1:0];
					default: begin
					end
				endcase
			end

			// Advance the pass; close it once the count reaches the length.
			if (state_q == ST_ACCUM) begin
				sum_q <= sum_next;
				items_q <= pass_last ? '0 : items_next;
			end
			// The root unit samples the sum on launch; drop it here.
			if (state_q == ST_LAUNCH) sum_q <= '0;

			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the accepted beat and the pending result.
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (load_res) res_q <= res_d;
	end

	// The root unit reports completion only while the sequencer waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_ROOT)
		else $error("root unit finished outside the root wait");

	// A closed pass leaves a cleared accumulator while the root runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> (sum_q == '0 && items_q == '0))
		else $error("accumulator not cleared at end of pass");

	// The element count never passes the longest selectable vector.
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(items_q) < LEN_LIMIT || LEN_LIMIT == 1 && items_q == '0)
		else $error("element count past length limit");

	// A pending result that is stalled keeps the new one waiting in delivery.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DELIVER && res_valid_q && result_stall) |=> state_q == ST_DELIVER)
		else $error("result register overwritten while stalled");

endmodule

// ===== rtl/core/rmsn_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing; operand widths come from the parent.
module rmsn_mul #(
	parameter int A_W = 30,
	parameter int B_W = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  prod_q
);

	// Hold the product until the next issue.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== rtl/core/rmsn_root.sv =====
// End-of-pass unit: mean by restoring division, integer square root, reciprocal.
// One shared compare-subtract step serves all three phases. Depends on rmsn_pkg.
module rmsn_root #(
	parameter int MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEFAULT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [rmsn_pkg::sum_width(MAX_LENGTH)-1:0]  sum,
	input  logic [rmsn_pkg::len_width(MAX_LENGTH)-1:0]  len,
	input  logic [rmsn_pkg::EPS_W-1:0]                  epsilon,
	output logic                                        done,
	output logic [rmsn_pkg::INV_W-1:0]                  inv
);
	import rmsn_pkg::*;

	localparam int SUM_W = sum_width(MAX_LENGTH);
	localparam int LEN_W = len_width(MAX_LENGTH);
	localparam int M_W = SUM_W + 1;
	localparam int ROOT_W = (M_W + 1) / 2;
	localparam int SRC_W = (2 * ROOT_W > INV_W) ? 2 * ROOT_W : INV_W;
	localparam int QW = SRC_W;
	localparam int RW = (ROOT_W + 3 > LEN_W + 1) ? ROOT_W + 3 : LEN_W + 1;
	localparam int STEP_W = $clog2(SRC_W + 1);

	root_phase_t phase_q, phase_d;

	logic [SRC_W-1:0]  src_q, src_next;
	logic [RW-1:0]     rem_q, rem_next, rem_shift, trial;
	logic [QW-1:0]     quo_q, quo_next;
	logic [RW-1:0]     div_q;
	logic [STEP_W-1:0] step_q;
	logic [INV_W-1:0]  inv_q;
	logic [M_W-1:0]    m_val;
	logic [ROOT_W-1:0] root_val;
	logic              sqrt_mode;
	logic              fit;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			RP_IDLE: begin
				if (start) phase_d = RP_DIVIDE;
			end
			RP_DIVIDE: begin
				if (step_q == STEP_W'(1)) phase_d = RP_OFFSET;
			end
			RP_OFFSET: phase_d = RP_ROOT;
			RP_ROOT: begin
				if (step_q == STEP_W'(1)) phase_d = RP_SETUP;
			end
			RP_SETUP: begin
				phase_d = (root_val == '0) ? RP_DONE : RP_RECIP;
			end
			RP_RECIP: begin
				if (step_q == STEP_W'(1)) phase_d = RP_DONE;
			end
			RP_DONE: phase_d = RP_IDLE;
			default: phase_d = RP_IDLE;
		endcase
	end

	// Phase outputs
	always_comb begin
		sqrt_mode = (phase_q == RP_ROOT);
		done = (phase_q == RP_DONE);
	end

	// Shared compare-subtract step: two bits in for the root, one for division.
	always_comb begin
		if (sqrt_mode) begin
			rem_shift = {rem_q[RW-3:0], src_q[SRC_W-1 -: 2]};
			trial = {quo_q[RW-3:0], 2'b01};
			src_next = src_q << 2;
		end else begin
			rem_shift = {rem_q[RW-2:0], src_q[SRC_W-1]};
			trial = div_q;
			src_next = src_q << 1;
		end
		fit = (rem_shift >= trial);
		rem_next = fit ? rem_shift - trial : rem_shift;
		quo_next = {quo_q[QW-2:0], fit};
	end

	assign m_val = M_W'(quo_q[SUM_W-1:0]) + M_W'(epsilon);
	assign root_val = quo_q[ROOT_W-1:0];
	assign inv = inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RP_IDLE;
			inv_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == RP_DONE) inv_q <= quo_q[INV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			RP_IDLE: begin
				if (start) begin
					src_q <= SRC_W'(sum) << (SRC_W - SUM_W);
					rem_q <= '0;
					quo_q <= '0;
					div_q <= RW'(len);
					step_q <= STEP_W'(SUM_W);
				end
			end
			RP_DIVIDE, RP_ROOT, RP_RECIP: begin
				src_q <= src_next;
				rem_q <= rem_next;
				quo_q <= quo_next;
				step_q <= step_q - STEP_W'(1);
			end
			RP_OFFSET: begin
				src_q <= SRC_W'(m_val) << (SRC_W - 2 * ROOT_W);
				rem_q <= '0;
				quo_q <= '0;
				step_q <= STEP_W'(ROOT_W);
			end
			RP_SETUP: begin
				if (root_val == '0) begin
					// Root of zero: reciprocal saturates to one in Q24
					quo_q <= QW'(ONE_Q24);
				end else begin
					div_q <= RW'(root_val);
					src_q <= SRC_W'(ONE_Q24) << (SRC_W - INV_W);
					rem_q <= '0;
					quo_q <= '0;
					step_q <= STEP_W'(INV_W);
				end
			end
			RP_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== bench/rms_normalizer_top_tb.sv =====
// Self-checking bench for rms_normalizer_top: directed table, then random vector passes.
// A behavioral model of the two-pass fixed-point RMS norm predicts every result beat.
// Depends on rmsn_pkg and rms_normalizer_top.
module rms_normalizer_top_tb;
	import rmsn_pkg::*;

	// A pass-closing item runs the root/reciprocal unit after its beat is accepted, so hold
	// off this long before touching a register or ending the run.
	localparam int SETTLE_CYCLES = 160;
	// Cycles with no beat accepted on any channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int MAX_LEN = MAX_LENGTH_DEFAULT;
	localparam int DIRECTED_ROWS = 30;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	// One directed step: either an item beat or a register write. Rows with
	// 'fixed' set carry their expected result inline instead of using the model.
	typedef struct {
		row_kind_t kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
		logic op;
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] gain;
		bit fixed;
		logic signed [SAMPLE_BITS-1:0] y;
		bit sat;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Model state: mirrors the block's accumulator, count, reciprocal and registers.
	logic [63:0] square_acc;
	logic [63:0] squares_seen;
	logic [63:0] inv_rms;
	logic [LENGTH_W-1:0] length_reg;
	logic [EPS_W-1:0] eps_reg;

	result_t pending_norms[$];

	int fail_count = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int norms_checked = 0;
	int sat_seen = 0;
	int reg_writes = 0;
	int passes_closed = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	rms_normalizer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Directed steps, walked in order after reset.
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		// normalize before any pass: the reciprocal is still zero
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 32767, 32767, 1, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, -32768, -32768, 1, 0, 0},
		// start a 4096-long pass, then shrink the length mid-pass
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 0, -1, 0, 0, 0},
		'{ROW_CFG, REG_VECTOR_LENGTH, 1, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_EPSILON, 0, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		// all-zero vector with zero epsilon: root of zero, reciprocal forced to one
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		// huge reciprocal clips at both rails
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 32767, 32767, 1, 32767, 1},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, -32768, 32767, 1, -32768, 1},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, -32768, -32768, 1, 32767, 1},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 1, 4096, 0, 0, 0},
		// length zero behaves as one
		'{ROW_CFG, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, -32768, 32767, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, -32768, 4096, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 32767, -32768, 0, 0, 0},
		// epsilon at its widest code, above one
		'{ROW_CFG, REG_EPSILON, 25'h1FFFFFF, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_VECTOR_LENGTH, 4, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 32767, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, -1, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 12345, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 5000, -7000, 0, 0, 0},
		// epsilon exactly one, then a pass cut short by a smaller length
		'{ROW_CFG, REG_EPSILON, 25'h1000000, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_VECTOR_LENGTH, 6, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 1, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 2, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, 3, 0, 0, 0, 0},
		'{ROW_CFG, REG_VECTOR_LENGTH, 2, OP_ACCUMULATE, 0, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_ACCUMULATE, -4, 0, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, -32768, 32767, 0, 0, 0},
		'{ROW_ITEM, REG_VECTOR_LENGTH, 0, OP_NORMALIZE, 0, 32767, 0, 0, 0}
	};

	function automatic logic [63:0] isqrt_floor(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] probe;
		logic [63:0] rem;
		root = '0;
		rem = n;
		probe = 64'h1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] active_length();
		if (length_reg == 0)
			return 64'd1;
		if (length_reg > MAX_LEN)
			return 64'(MAX_LEN);
		return 64'(length_reg);
	endfunction

	// Advance the model by one item; a normalize beat yields one weighted, saturated y.
	task automatic compute_rms_step(input item_t it, output bit produces, output result_t res);
		longint xs;
		longint gs;
		longint t;
		longint y;
		logic [63:0] len;
		logic [63:0] s;
		xs = longint'($signed(it.x_value));
		gs = longint'($signed(it.gain));
		res = '0;
		produces = 1'b0;
		if (it.op == OP_ACCUMULATE) begin
			len = active_length();
			square_acc = square_acc + 64'(xs * xs);
			squares_seen = squares_seen + 1;
			if (squares_seen >= len) begin
				s = isqrt_floor(square_acc / len + 64'(eps_reg));
				inv_rms = (s == 0) ? 64'(ONE_Q24) : 64'(ONE_Q24) / s;
				square_acc = '0;
				squares_seen = '0;
				passes_closed++;
			end
		end else begin
			// both shifts are arithmetic, i.e. floor division by 2^12
			t = (xs * longint'(inv_rms)) >>> FRAC_BITS;
			y = (t * gs) >>> FRAC_BITS;
			res.saturated = 1'b0;
			if (y > 32767) begin
				y = 32767;
				res.saturated = 1'b1;
			end else if (y < -32768) begin
				y = -32768;
				res.saturated = 1'b1;
			end
			res.y_value = y[SAMPLE_BITS-1:0];
			produces = 1'b1;
		end
	endtask

	// Mostly full-range values; rails and tiny magnitudes show up often.
	function automatic logic [SAMPLE_BITS-1:0] random_q12();
		logic [SAMPLE_BITS-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: begin
				v = 16'($urandom_range(0, 15));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Drive one item beat and hold it until accepted. Entered and left at a falling edge.
	task automatic send_item(input item_t it, input bit fixed, input result_t fixed_res);
		int gap;
		bit produces;
		result_t predicted;
		gap = send_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		compute_rms_step(it, produces, predicted);
		if (produces)
			pending_norms.push_back(fixed ? fixed_res : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Let the block go fully idle: no result owed, and the root unit finished.
	task automatic settle();
		item_valid = 1'b0;
		while (pending_norms.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_VECTOR_LENGTH)
			length_reg = value[LENGTH_W-1:0];
		else if (idx == REG_EPSILON)
			eps_reg = value[EPS_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: stall a random number of cycles per beat, then take the next
	// beat and compare it with the oldest prediction.
	initial begin
		int hold;
		result_t want;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = recv_quiet ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			if (pending_norms.size() == 0) begin
				$error("unexpected result beat: y_value %0d saturated %0d",
					result.y_value, result.saturated);
				fail_count++;
			end else begin
				want = pending_norms.pop_front();
				if (result.y_value !== want.y_value) begin
					$error("y_value mismatch: expected %0d, actual %0d",
						want.y_value, result.y_value);
					fail_count++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated mismatch: expected %0d, actual %0d",
						want.saturated, result.saturated);
					fail_count++;
				end
				norms_checked++;
				if (want.saturated)
					sat_seen++;
			end
			@(negedge clk);
		end
	end

	// Watchdog: any accepted beat on any channel resets the idle count.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a beat, %0d results still owed",
				idle_cycles, pending_norms.size());
			$display("rms_normalizer_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		item_t it;
		result_t fixed_res;
		int random_items;
		int phase;
		int count;
		int shape;
		int span;
		logic [CFG_DATA_W-1:0] value;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VECTOR_LENGTH;
		cfg_data = '0;
		length_reg = VECTOR_LENGTH_RESET;
		eps_reg = EPSILON_RESET;
		square_acc = '0;
		squares_seen = '0;
		inv_rms = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				it.op = directed_rows[i].op;
				it.x_value = directed_rows[i].x;
				it.gain = directed_rows[i].gain;
				fixed_res.y_value = directed_rows[i].y;
				fixed_res.saturated = directed_rows[i].sat;
				send_item(it, directed_rows[i].fixed, fixed_res);
			end
		end

		// Random phases: each may retune the registers, then runs one sequence.
		// Most sequences are complete passes followed by normalize beats; the rest
		// are random op mixes or passes left unfinished across a register write.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: value = '0;
					1: value = CFG_DATA_W'(ONE_Q24);
					2: value = 25'h1FFFFFF;
					3: value = CFG_DATA_W'($urandom_range(0, 1023));
					default: value = CFG_DATA_W'($urandom);
				endcase
				write_register(REG_EPSILON, value);
			end
			// Two phases go to the top of the length range and past it (clamped); they
			// send only a short partial pass, which the next phase cuts with a shorter length.
			if (phase == 3 || phase == 9) begin
				write_register(REG_VECTOR_LENGTH, (phase == 3) ? 25'd4096 : 25'd8191);
			end else if (active_length() > 300 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: value = '0;
					1: value = 25'd1;
					2: value = CFG_DATA_W'($urandom_range(33, 300));
					default: value = CFG_DATA_W'($urandom_range(2, 32));
				endcase
				write_register(REG_VECTOR_LENGTH, value);
			end

			shape = (phase == 3 || phase == 9) ? 9 : $urandom_range(0, 9);
			if (shape <= 7) begin
				// finish the pass in progress, then normalize a handful
				count = int'(active_length() - squares_seen);
				if (count < 1)
					count = 1;
				repeat (count) begin
					it.op = OP_ACCUMULATE;
					it.x_value = random_q12();
					it.gain = random_q12();
					send_item(it, 1'b0, fixed_res);
					random_items++;
				end
				repeat ($urandom_range(1, 24)) begin
					it.op = OP_NORMALIZE;
					it.x_value = random_q12();
					it.gain = random_q12();
					send_item(it, 1'b0, fixed_res);
					random_items++;
				end
			end else if (shape == 8) begin
				repeat ($urandom_range(1, 20)) begin
					it.op = $urandom_range(0, 1) ? OP_NORMALIZE : OP_ACCUMULATE;
					it.x_value = random_q12();
					it.gain = random_q12();
					send_item(it, 1'b0, fixed_res);
					random_items++;
				end
			end else begin
				// partial pass; the next phase may change the length under it
				span = (active_length() > 64) ? 64 : int'(active_length());
				repeat ($urandom_range(1, span)) begin
					it.op = OP_ACCUMULATE;
					it.x_value = random_q12();
					it.gain = random_q12();
					send_item(it, 1'b0, fixed_res);
					random_items++;
				end
				repeat ($urandom_range(1, 8)) begin
					it.op = OP_NORMALIZE;
					it.x_value = random_q12();
					it.gain = random_q12();
					send_item(it, 1'b0, fixed_res);
					random_items++;
				end
			end
			phase++;
		end

		// Drain: every owed result, then the root unit's worst case.
		settle();

		$display("Run covered %0d item beats over %0d random phases and %0d register writes;",
			items_sent, phase, reg_writes);
		$display("%0d passes closed, %0d normalized beats checked, %0d of them clipped.",
			passes_closed, norms_checked, sat_seen);
		if (fail_count == 0 && pending_norms.size() == 0) begin
			$display("rms_normalizer_top test passed");
		end else begin
			$display("rms_normalizer_top test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rmsn_pkg.sv
rtl/core/rmsn_mul.sv
rtl/core/rmsn_root.sv
rtl/core/rms_normalizer_top.sv
bench/rms_normalizer_top_tb.sv
